/* hw/rtl/srsg_pkg.sv */
// Package for the stepper ramp step generator: widths, ramp constants and opcodes.
package srsg_pkg;

  localparam int POS_W      = 16;
  localparam int DELAY_W    = 10;
  localparam int BASE_W     = 9;
  localparam int PERIOD_W   = 11;
  localparam int STEPS_W    = 16;
  localparam int THRESH_W   = 12;

  localparam int RAMP_STEPS = 60;
  localparam int BASE_START = 420;
  localparam int BASE_MAX   = 511;
  localparam int PERIOD_ADD = 70;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MOVE = 1'b1
  } srsg_op_t;

endpackage

/* hw/rtl/srsg_if.sv */
// Channel interfaces of the stepper ramp step generator: command input and pin status output.
interface srsg_in_if;
  logic                                 valid;
  logic                                 ready;
  srsg_pkg::srsg_op_t                   opcode;
  logic signed [srsg_pkg::POS_W-1:0]    target_position;
  logic [srsg_pkg::DELAY_W-1:0]         extra_delay;

  modport source (output valid, output opcode, output target_position, output extra_delay,
                  input ready);
  modport sink   (input valid, input opcode, input target_position, input extra_delay,
                  output ready);
endinterface

interface srsg_out_if;
  logic valid;
  logic ready;
  logic step_level;
  logic dir_forward;
  logic dir_reverse;
  logic busy_res;
  logic move_accepted;

  modport source (output valid, output step_level, output dir_forward, output dir_reverse,
                  output busy_res, output move_accepted, input ready);
  modport sink   (input valid, input step_level, input dir_forward, input dir_reverse,
                  input busy_res, input move_accepted, output ready);
endinterface

/* hw/rtl/stepper_ramp_step_generator_core.sv */
// Stepper ramp step generator: move command intake, tick-driven step timing and ramp.
// Each input transfer writes its result into the output register on the following clock edge.
// Throughput: one item per cycle; the motion state updates in a single pass per item
//   and the output register accepts a new item whenever it is empty or its held result is being taken.
// Reset (rst_n low, synchronous): no steps pending, position zero, all pins low,
//   period counter zero, output register empty.
module stepper_ramp_step_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  srsg_in_if.sink     in_chan,
  srsg_out_if.source  out_chan
);
  import srsg_pkg::*;

  // Motion state
  logic [STEPS_W-1:0]        steps_left_r,  steps_left_nxt;
  logic [STEPS_W-1:0]        steps_move_r,  steps_move_nxt;
  logic signed [POS_W-1:0]   cmd_pos_r,     cmd_pos_nxt;
  logic [BASE_W-1:0]         base_r,        base_nxt;
  logic [DELAY_W-1:0]        extra_r,       extra_nxt;
  logic [PERIOD_W-1:0]       period_r,      period_nxt;
  logic                      toggle_r,      toggle_nxt;
  logic                      step_pin_r,    step_pin_nxt;
  logic                      fwd_pin_r,     fwd_pin_nxt;
  logic                      rev_pin_r,     rev_pin_nxt;

  // Output register
  logic                      out_valid_r;
  logic                      acc_r,         acc_nxt;

  logic                      xfer_in;

  // Move command datapath
  logic signed [POS_W:0]     delta;
  logic [POS_W:0]            delta_mag;

  // Tick datapath
  logic                      step_now;
  logic [STEPS_W-1:0]        sl_dec;
  logic [STEPS_W-1:0]        done_cnt;
  logic [STEPS_W-1:0]        ramp_dn_k;
  logic [STEPS_W-1:0]        ramp_up_k;
  logic [BASE_W:0]           dec_amt;
  logic [BASE_W:0]           inc_amt;
  logic [BASE_W:0]           base_inc;
  logic [BASE_W-1:0]         base_step;
  logic [BASE_W-1:0]         base_tick;
  logic [THRESH_W-1:0]       threshold;

  // Accept a new item whenever the output slot is empty or drains this cycle.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign xfer_in       = in_chan.valid && in_chan.ready;

  // Move: signed distance from the commanded position; magnitude fits 16 bits.
  assign delta     = (POS_W+1)'(in_chan.target_position) - (POS_W+1)'(cmd_pos_r);
  assign delta_mag = delta[POS_W] ? (POS_W+1)'(-delta) : (POS_W+1)'(delta);

  // Tick: a step fires when the period counter sits at zero with steps pending.
  assign step_now  = (period_r == '0) && (steps_left_r != '0);
  assign sl_dec    = steps_left_r - STEPS_W'(1);
  assign done_cnt  = steps_move_r - sl_dec;
  assign ramp_dn_k = STEPS_W'(RAMP_STEPS) - done_cnt;
  assign ramp_up_k = STEPS_W'(RAMP_STEPS) - sl_dec;
  // Quarter-rate ramp amounts; both lie between zero and RAMP_STEPS / 4 where used.
  assign dec_amt   = (BASE_W+1)'(ramp_dn_k >> 2);
  assign inc_amt   = (BASE_W+1)'(ramp_up_k >> 2);
  assign base_inc  = {1'b0, base_r} + inc_amt;

  always_comb begin
    if (done_cnt < STEPS_W'(RAMP_STEPS)) begin
      // Acceleration: shrink the interval, floor at zero.
      if (dec_amt > {1'b0, base_r}) begin
        base_step = '0;
      end else begin
        base_step = BASE_W'({1'b0, base_r} - dec_amt);
      end
    end else if (sl_dec < STEPS_W'(RAMP_STEPS)) begin
      // Deceleration: grow the interval, cap at the top of the range.
      if (base_inc > (BASE_W+1)'(BASE_MAX)) begin
        base_step = BASE_W'(BASE_MAX);
      end else begin
        base_step = BASE_W'(base_inc);
      end
    end else begin
      base_step = base_r;
    end
  end

  // Period threshold uses the interval as updated by this tick.
  assign base_tick = step_now ? base_step : base_r;
  assign threshold = THRESH_W'(base_tick) + THRESH_W'(extra_r) + THRESH_W'(PERIOD_ADD);

  always_comb begin
    steps_left_nxt = steps_left_r;
    steps_move_nxt = steps_move_r;
    cmd_pos_nxt    = cmd_pos_r;
    base_nxt       = base_r;
    extra_nxt      = extra_r;
    period_nxt     = period_r;
    toggle_nxt     = toggle_r;
    step_pin_nxt   = step_pin_r;
    fwd_pin_nxt    = fwd_pin_r;
    rev_pin_nxt    = rev_pin_r;
    acc_nxt        = 1'b0;

    case (in_chan.opcode)
      OP_MOVE: begin
        // Take the move only when idle; a refused move changes nothing.
        if (steps_left_r == '0) begin
          extra_nxt      = in_chan.extra_delay;
          cmd_pos_nxt    = in_chan.target_position;
          fwd_pin_nxt    = !delta[POS_W];
          rev_pin_nxt    = delta[POS_W];
          steps_move_nxt = STEPS_W'(delta_mag);
          steps_left_nxt = STEPS_W'(delta_mag);
          base_nxt       = BASE_W'(BASE_START);
          acc_nxt        = 1'b1;
        end
      end
      OP_TICK: begin
        if (step_now) begin
          steps_left_nxt = sl_dec;
          base_nxt       = base_step;
          // Alternate the pin: first edge after reset drives it low.
          toggle_nxt     = !toggle_r;
          step_pin_nxt   = toggle_r;
        end
        // Period counter runs on every tick, busy or not.
        if (THRESH_W'(period_r) > threshold) begin
          period_nxt = '0;
        end else begin
          period_nxt = period_r + PERIOD_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control and motion state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_left_r <= '0;
      steps_move_r <= '0;
      cmd_pos_r    <= '0;
      base_r       <= '0;
      extra_r      <= '0;
      period_r     <= '0;
      toggle_r     <= 1'b0;
      step_pin_r   <= 1'b0;
      fwd_pin_r    <= 1'b0;
      rev_pin_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (xfer_in) begin
        steps_left_r <= steps_left_nxt;
        steps_move_r <= steps_move_nxt;
        cmd_pos_r    <= cmd_pos_nxt;
        base_r       <= base_nxt;
        extra_r      <= extra_nxt;
        period_r     <= period_nxt;
        toggle_r     <= toggle_nxt;
        step_pin_r   <= step_pin_nxt;
        fwd_pin_r    <= fwd_pin_nxt;
        rev_pin_r    <= rev_pin_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // Result payload: hold the acceptance flag of the item in the output slot.
  always_ff @(posedge clk) begin
    if (xfer_in) begin
      acc_r <= acc_nxt;
    end
  end

  // Pins and busy come straight from state, which only moves on an input transfer.
  assign out_chan.valid         = out_valid_r;
  assign out_chan.step_level    = step_pin_r;
  assign out_chan.dir_forward   = fwd_pin_r;
  assign out_chan.dir_reverse   = rev_pin_r;
  assign out_chan.busy_res      = (steps_left_r != '0);
  assign out_chan.move_accepted = acc_r;

endmodule

/* tb/sv/tb_stepper_ramp_step_generator_core.sv */
// Testbench for the stepper ramp step generator: directed table, random items, scoreboard.
`timescale 1ns / 1ps

module tb_stepper_ramp_step_generator_core;
  import srsg_pkg::*;

  localparam int CYCLE_LIMIT = 50_000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 10;
  localparam int REPORT_MAX  = 10;
  localparam int PHASE_ITEMS = 136;
  localparam int MOVE_PCT    = 5;

  // Pin and status bits of one result transfer, in port order.
  typedef struct packed {
    logic step;
    logic fwd;
    logic rev;
    logic busy;
    logic acc;
  } pin_status_t;

  // One row of the directed plan.
  typedef struct {
    srsg_op_t                  op;
    logic signed [POS_W-1:0]   tgt;
    logic [DELAY_W-1:0]        dly;
    bit                        typed;
    pin_status_t               want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  srsg_in_if  in_chan ();
  srsg_out_if out_chan ();

  stepper_ramp_step_generator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  // Motion state mirrored from the block; all zero after reset.
  logic [STEPS_W-1:0]      steps_left   = '0;
  logic [STEPS_W-1:0]      steps_total  = '0;
  logic signed [POS_W-1:0] cmd_pos      = '0;
  logic [BASE_W-1:0]       base_ticks   = '0;
  logic [DELAY_W-1:0]      extra_ticks  = '0;
  logic [PERIOD_W-1:0]     period_cnt   = '0;
  bit                      step_toggle  = 1'b0;
  logic [2:0]              pins         = '0;   // bit0 step, bit1 forward, bit2 reverse

  pin_status_t pending_status[$];
  int          mismatch_cnt = 0;
  int          idle_pct     = 0;
  int          stall_pct    = 0;
  int          hold_reqs    = 0;
  int          cycle_cnt    = 0;

  dir_row_t plan [8];

  // Apply one accepted item to the mirrored state and return the pin status it leaves.
  function automatic pin_status_t advance_motion(input srsg_op_t op,
                                                 input logic signed [POS_W-1:0] tgt,
                                                 input logic [DELAY_W-1:0] dly);
    int          delta;
    int          done;
    int          k;
    int          nb;
    int          thr;
    pin_status_t res;
    res.acc = 1'b0;
    if (op == OP_MOVE) begin
      // Moves are refused while steps remain.
      if (steps_left == 0) begin
        delta       = int'(tgt) - int'(cmd_pos);
        extra_ticks = dly;
        cmd_pos     = tgt;
        if (delta < 0) begin
          delta = -delta;
          pins  = {1'b1, 1'b0, pins[0]};
        end else begin
          pins  = {1'b0, 1'b1, pins[0]};
        end
        steps_total = delta[STEPS_W-1:0];
        steps_left  = steps_total;
        base_ticks  = BASE_W'(BASE_START);
        res.acc     = 1'b1;
      end
    end else begin
      if (period_cnt == 0 && steps_left != 0) begin
        steps_left = steps_left - 1'b1;
        done       = int'(steps_total) - int'(steps_left);
        nb         = int'(base_ticks);
        // Shrink the interval while accelerating, grow it on the final approach.
        if (done < RAMP_STEPS) begin
          k  = int'(steps_left) - (int'(steps_total) - RAMP_STEPS);
          nb = nb - k / 4;
        end else if (int'(steps_left) < RAMP_STEPS) begin
          nb = nb + (RAMP_STEPS - int'(steps_left)) / 4;
        end
        if (nb < 0) nb = 0;
        if (nb > BASE_MAX) nb = BASE_MAX;
        base_ticks = nb[BASE_W-1:0];
        // The first edge after reset drives the pin low, then it alternates.
        if (step_toggle) begin
          step_toggle = 1'b0;
          pins[0]     = 1'b1;
        end else begin
          step_toggle = 1'b1;
          pins[0]     = 1'b0;
        end
      end
      thr = int'(base_ticks) + int'(extra_ticks) + PERIOD_ADD;
      if (int'(period_cnt) > thr) period_cnt = '0;
      else period_cnt = period_cnt + 1'b1;
    end
    res.step = pins[0];
    res.fwd  = pins[1];
    res.rev  = pins[2];
    res.busy = (steps_left != 0);
    return res;
  endfunction

  // Offer one item, hold it until the transfer, then queue what it should produce.
  task automatic offer(input srsg_op_t op, input logic signed [POS_W-1:0] tgt,
                       input logic [DELAY_W-1:0] dly, input bit typed,
                       input pin_status_t want);
    pin_status_t calc;
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.opcode          <= op;
    in_chan.target_position <= tgt;
    in_chan.extra_delay     <= dly;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    calc = advance_motion(op, tgt, dly);
    pending_status.push_back(typed ? want : calc);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the sender asks for one.
  initial begin
    int seen;
    int hold;
    seen = 0;
    hold = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != seen) begin
        seen = hold_reqs;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Scoreboard: each result transfer against the oldest expected status.
  always @(posedge clk) begin
    pin_status_t got;
    pin_status_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = {out_chan.step_level, out_chan.dir_forward, out_chan.dir_reverse,
             out_chan.busy_res, out_chan.move_accepted};
      if (pending_status.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("[%0t] unexpected result: step=%b fwd=%b rev=%b busy=%b acc=%b",
                   $realtime, got.step, got.fwd, got.rev, got.busy, got.acc);
      end else begin
        want = pending_status.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display({"[%0t] mismatch: exp step=%b fwd=%b rev=%b busy=%b acc=%b,",
                      " got step=%b fwd=%b rev=%b busy=%b acc=%b"},
                     $realtime, want.step, want.fwd, want.rev, want.busy, want.acc,
                     got.step, got.fwd, got.rev, got.busy, got.acc);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic signed [POS_W-1:0] tgt;
    logic [DELAY_W-1:0]      dly;
    rst_n                   <= 1'b0;
    in_chan.valid           <= 1'b0;
    in_chan.opcode          <= OP_TICK;
    in_chan.target_position <= '0;
    in_chan.extra_delay     <= '0;

    // Directed plan. Typed-in results only where they are obvious: right after
    // reset, a one-step move, and refused moves at the extremes. The first tick
    // lands with the period counter still at zero, so it fires a step at once.
    plan = '{
      '{OP_MOVE, 16'sh0000, 10'd0,    1'b1, 5'b01001},  // to current position
      '{OP_MOVE, 16'shFFFF, 10'd0,    1'b1, 5'b00111},  // one step reverse
      '{OP_MOVE, 16'sh7FFF, 10'd1023, 1'b1, 5'b00110},  // refused while busy
      '{OP_MOVE, 16'sh8000, 10'd0,    1'b1, 5'b00110},  // refused while busy
      '{OP_TICK, 16'sh5555, 10'd341,  1'b0, 5'b00000},  // first edge drives the pin low
      '{OP_MOVE, 16'sh0000, 10'd0,    1'b0, 5'b00000},  // one step forward
      '{OP_TICK, 16'sh7FFF, 10'd1023, 1'b0, 5'b00000},
      '{OP_TICK, 16'sh8000, 10'd0,    1'b0, 5'b00000}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      offer(plan[i].op, plan[i].tgt, plan[i].dly, plan[i].typed, plan[i].want);
    end

    // Random items in four idling phases: free flow, sender gaps, receiver
    // stalls, both. Mostly ticks, so the pending step comes due and raises the
    // pin; moves land near the commanded position, now and then anywhere.
    for (int p = 0; p < 4; p++) begin
      idle_pct  = (p == 1) ? 69 : (p == 3) ? 31 : 0;
      stall_pct = (p == 2) ? 69 : (p == 3) ? 31 : 0;
      // Hold off the receiver for a while so the block fills and stalls its input.
      if (p == 0) hold_reqs++;
      for (int e = 0; e < PHASE_ITEMS; e++) begin
        if ($urandom_range(99) < MOVE_PCT) begin
          if ($urandom_range(3) == 0) tgt = POS_W'($urandom);
          else tgt = POS_W'(int'(cmd_pos) + int'($urandom_range(0, 8)) - 4);
          dly = ($urandom_range(3) == 0) ? DELAY_W'($urandom_range(0, 1023))
                                         : DELAY_W'($urandom_range(0, 7));
          offer(OP_MOVE, tgt, dly, 0, '0);
        end else begin
          offer(OP_TICK, POS_W'($urandom), DELAY_W'($urandom), 0, '0);
        end
      end
    end

    in_chan.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
